>>> design/mmio_mov_instruction_decoder_macros.svh
// ----------------------------------------------------------------------------
// MMIO move decoder assertion macros
// Clocked, reset-qualified immediate and next-cycle implication checks.
// ----------------------------------------------------------------------------
`ifndef MMIO_MOV_INSTRUCTION_DECODER_MACROS_SVH
`define MMIO_MOV_INSTRUCTION_DECODER_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define MMD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define MMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/mmd_pkg.sv
// ----------------------------------------------------------------------------
// MMIO move decoder package
// Types, byte codes, descriptor layout and ModRM plan for the byte-serial move decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mmd_pkg;

  localparam logic [3:0] MAX_LENGTH = 4'd15;

  // Decode phases, one-hot.
  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_OP2   = 5'b00010,
    PH_MODRM = 5'b00100,
    PH_SKIP  = 5'b01000,
    PH_IMM   = 5'b10000
  } phase_e;

  typedef enum logic [2:0] {
    ACT_WRITE_REG = 3'd0,
    ACT_WRITE_IMM = 3'd1,
    ACT_READ_REG  = 3'd2,
    ACT_STRING    = 3'd3,
    ACT_ERROR     = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    SEG_ES = 3'd0,
    SEG_CS = 3'd1,
    SEG_SS = 3'd2,
    SEG_DS = 3'd3,
    SEG_FS = 3'd4,
    SEG_GS = 3'd5
  } segment_e;

  localparam logic [7:0] PFX_ES     = 8'h26;
  localparam logic [7:0] PFX_CS     = 8'h2E;
  localparam logic [7:0] PFX_SS     = 8'h36;
  localparam logic [7:0] PFX_DS     = 8'h3E;
  localparam logic [7:0] PFX_FS     = 8'h64;
  localparam logic [7:0] PFX_GS     = 8'h65;
  localparam logic [7:0] PFX_OPSIZE = 8'h66;
  localparam logic [7:0] PFX_ADSIZE = 8'h67;
  localparam logic [7:0] PFX_REP    = 8'hF3;

  localparam logic [7:0] OP_ESCAPE  = 8'h0F;
  localparam logic [7:0] OP_MOV_RB  = 8'h88;
  localparam logic [7:0] OP_MOV_RV  = 8'h89;
  localparam logic [7:0] OP_LD_RB   = 8'h8A;
  localparam logic [7:0] OP_LD_RV   = 8'h8B;
  localparam logic [7:0] OP_LD_MOFS = 8'hA1;
  localparam logic [7:0] OP_ST_MOFS = 8'hA3;
  localparam logic [7:0] OP_MOVSB   = 8'hA4;
  localparam logic [7:0] OP_MOVSV   = 8'hA5;
  localparam logic [7:0] OP_MOV_IB  = 8'hC6;
  localparam logic [7:0] OP_MOV_IV  = 8'hC7;
  localparam logic [7:0] OP_MOVZX_W = 8'hB7;

  localparam logic [1:0] MOD_IND   = 2'd0;
  localparam logic [1:0] MOD_DISP8 = 2'd1;
  localparam logic [1:0] MOD_DISP  = 2'd2;
  localparam logic [2:0] RM_SIB    = 3'b100;
  localparam logic [2:0] RM_DISP   = 3'b101;

  // Result of looking at a ModRM byte.
  typedef struct packed {
    logic       ok;
    logic [2:0] skip;
    logic [2:0] imm;
  } modrm_plan_t;

  // One decoded descriptor.
  typedef struct packed {
    action_e    action;
    logic [2:0] register_index;
    logic [2:0] access_size;
    logic [31:0] immediate_value;
    logic [3:0] instruction_length;
    logic [2:0] segment_select;
    logic       repeat_flag;
    logic [2:0] addr_bytes;
  } descriptor_t;

  function automatic modrm_plan_t plan_modrm(input logic [7:0] opcode,
                                             input logic [7:0] modrm,
                                             input logic op4,
                                             input logic addr4);
    modrm_plan_t p;
    logic [1:0] md;
    logic r4;
    logic r5;
    md = modrm[7:6];
    r4 = (modrm[2:0] == RM_SIB);
    r5 = (modrm[2:0] == RM_DISP);
    p  = '0;
    case (opcode)
      OP_MOV_RB: begin
        if (md == MOD_IND && !r5) begin
          p.ok = 1'b1; p.skip = r4 ? 3'd1 : 3'd0;
        end else if (md == MOD_DISP8 && r4) begin
          p.ok = 1'b1; p.skip = 3'd2;
        end
      end
      OP_MOV_RV: begin
        if (md == MOD_IND && !r5) begin
          p.ok = 1'b1; p.skip = r4 ? 3'd1 : 3'd0;
        end else if (md == MOD_DISP8 && !r4 && !r5) begin
          p.ok = 1'b1; p.skip = 3'd1;
        end else if (md == MOD_DISP && !r4 && !r5) begin
          p.ok = 1'b1; p.skip = 3'd4;
        end
      end
      OP_LD_RB: begin
        p.ok = (md == MOD_IND) && !r4 && !r5;
      end
      OP_LD_RV: begin
        if (md == MOD_IND) begin
          p.ok = 1'b1;
          p.skip = r4 ? 3'd1 : (r5 ? (addr4 ? 3'd4 : 3'd2) : 3'd0);
        end else if (md == MOD_DISP8 && !r4) begin
          p.ok = 1'b1; p.skip = 3'd1;
        end else if (md == MOD_DISP && !r4) begin
          p.ok = 1'b1; p.skip = 3'd4;
        end
      end
      OP_MOV_IB: begin
        p.imm = 3'd1;
        if (md == MOD_IND && r4) begin
          p.ok = 1'b1; p.skip = 3'd1;
        end else if (md == MOD_DISP8 && r4) begin
          p.ok = 1'b1; p.skip = 3'd2;
        end else if (md == MOD_DISP) begin
          p.ok = 1'b1; p.skip = 3'd4;
        end
      end
      OP_MOV_IV: begin
        p.imm = op4 ? 3'd4 : 3'd2;
        if (md == MOD_IND && !r4) begin
          p.ok = 1'b1; p.skip = r5 ? 3'd4 : 3'd0;
        end else if (md == MOD_DISP8 && !r4 && !r5) begin
          p.ok = 1'b1; p.skip = 3'd1;
        end
      end
      OP_MOVZX_W: begin
        if (md == MOD_DISP8) begin
          p.ok = 1'b1; p.skip = 3'd1;
        end else if (md == MOD_DISP) begin
          p.ok = 1'b1; p.skip = 3'd4;
        end
      end
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

>>> design/mmio_mov_instruction_decoder.sv
// ----------------------------------------------------------------------------
// MMIO move instruction decoder
// Walks the bytes of a faulting x86 data-move instruction and returns one
// access descriptor (or an error) per instruction.
// ----------------------------------------------------------------------------
//  channel      | signals                                   | moves
//  -------------+-------------------------------------------+------------------
//  byte in      | in_valid_i / in_ready_o                   | one instruction byte
//  descriptor   | out_valid_o / out_ready_i                 | one descriptor
//  config (APB) | psel penable pwrite paddr pwdata prdata   | default_size_32
//
// One byte is taken per cycle; the decode of a byte is a single table step on
// the held prefix, opcode and ModRM fields. A descriptor sits in the output
// register from the cycle after the instruction's last byte; a new byte is
// taken in that same cycle unless the register is full and not being drained.
// Reset brings the decoder to idle with no prefixes and a 32-bit default size.
`timescale 1ns / 1ps

`include "mmio_mov_instruction_decoder_macros.svh"

module mmio_mov_instruction_decoder import mmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  instruction_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  action_o,
  output logic [2:0]  register_index_o,
  output logic [2:0]  access_size_o,
  output logic [31:0] immediate_value_o,
  output logic [3:0]  instruction_length_o,
  output logic [2:0]  segment_select_o,
  output logic        repeat_flag_o,
  output logic [2:0]  address_size_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        cfg_size32_q;
  phase_e      phase_q, phase_d;
  logic        opsz_q, opsz_d;
  logic        adsz_q, adsz_d;
  logic        rep_q, rep_d;
  logic [2:0]  seg_q, seg_d;
  logic [7:0]  opcode_q, opcode_d;
  logic [7:0]  modrm_q, modrm_d;
  logic [2:0]  skip_q, skip_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  imm_rem_q, imm_rem_d;
  logic [3:0]  count_q, count_d;

  logic        out_valid_q;
  descriptor_t desc_q, desc_d;

  logic        in_fire;
  logic        emit;
  logic        fail;
  logic [3:0]  count;
  logic        op4;
  logic        addr4;
  modrm_plan_t plan;
  logic [2:0]  skip_dec;
  logic [2:0]  imm_dec;

  // Configuration port: always ready, one register, written at indices 0 to 3 and read back at every index.
  assign pready = 1'b1;
  assign prdata = {31'd0, cfg_size32_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_size32_q <= 1'b1;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      cfg_size32_q <= pwdata[0];
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign count    = (count_q < 4'd15) ? count_q + 4'd1 : 4'd15;
  assign op4      = cfg_size32_q ^ opsz_d;
  assign addr4    = cfg_size32_q ^ adsz_d;
  assign plan     = plan_modrm(opcode_q, instruction_byte_i, op4, addr4);
  assign skip_dec = (skip_q != 3'd0) ? skip_q - 3'd1 : 3'd0;
  assign imm_dec  = (imm_rem_q != 3'd0) ? imm_rem_q - 3'd1 : 3'd0;

  always_comb begin
    phase_d   = phase_q;
    opsz_d    = opsz_q;
    adsz_d    = adsz_q;
    rep_d     = rep_q;
    seg_d     = seg_q;
    opcode_d  = opcode_q;
    modrm_d   = modrm_q;
    skip_d    = skip_q;
    acc_d     = acc_q;
    imm_rem_d = imm_rem_q;
    count_d   = count;
    emit      = 1'b0;
    fail      = 1'b0;

    case (phase_q)
      PH_IDLE: begin
        case (instruction_byte_i)
          PFX_ES:     seg_d  = SEG_ES;
          PFX_CS:     seg_d  = SEG_CS;
          PFX_SS:     seg_d  = SEG_SS;
          PFX_DS:     seg_d  = SEG_DS;
          PFX_FS:     seg_d  = SEG_FS;
          PFX_GS:     seg_d  = SEG_GS;
          PFX_OPSIZE: opsz_d = 1'b1;
          PFX_ADSIZE: adsz_d = 1'b1;
          PFX_REP:    rep_d  = 1'b1;
          OP_ESCAPE: begin
            opcode_d = instruction_byte_i;
            phase_d  = PH_OP2;
          end
          OP_MOV_RB, OP_MOV_RV, OP_LD_RB, OP_LD_RV, OP_MOV_IB, OP_MOV_IV: begin
            opcode_d = instruction_byte_i;
            phase_d  = PH_MODRM;
          end
          OP_LD_MOFS, OP_ST_MOFS: begin
            opcode_d  = instruction_byte_i;
            skip_d    = (cfg_size32_q ^ adsz_q) ? 3'd4 : 3'd2;
            imm_rem_d = 3'd0;
            phase_d   = PH_SKIP;
          end
          OP_MOVSB, OP_MOVSV: begin
            opcode_d = instruction_byte_i;
            emit     = 1'b1;
          end
          default: begin
            emit = 1'b1;
            fail = 1'b1;
          end
        endcase
      end
      PH_OP2: begin
        if (instruction_byte_i != OP_MOVZX_W) begin
          emit = 1'b1;
          fail = 1'b1;
        end else begin
          opcode_d = OP_MOVZX_W;
          phase_d  = PH_MODRM;
        end
      end
      PH_MODRM: begin
        modrm_d   = instruction_byte_i;
        skip_d    = plan.skip;
        imm_rem_d = plan.imm;
        acc_d     = 32'd0;
        if (!plan.ok) begin
          emit = 1'b1;
          fail = 1'b1;
        end else if (plan.skip != 3'd0) begin
          phase_d = PH_SKIP;
        end else if (plan.imm != 3'd0) begin
          phase_d = PH_IMM;
        end else begin
          emit = 1'b1;
        end
      end
      PH_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == 3'd0) begin
          if (imm_rem_q == 3'd0) begin
            emit = 1'b1;
          end else begin
            phase_d = PH_IMM;
          end
        end
      end
      PH_IMM: begin
        acc_d     = {instruction_byte_i, acc_q[31:8]};
        imm_rem_d = imm_dec;
        if (imm_dec == 3'd0) begin
          emit = 1'b1;
        end
      end
      default: begin
        emit = 1'b1;
        fail = 1'b1;
      end
    endcase

    // An instruction still open at the length limit is rejected.
    if (!emit && count >= MAX_LENGTH) begin
      emit = 1'b1;
      fail = 1'b1;
    end
  end

  // Descriptor built from the fields as they stand after this byte.
  always_comb begin
    desc_d                    = '0;
    desc_d.instruction_length = count;
    desc_d.segment_select     = seg_d;
    desc_d.repeat_flag        = rep_d;
    desc_d.addr_bytes         = addr4 ? 3'd4 : 3'd2;
    desc_d.action             = ACT_ERROR;
    if (!fail) begin
      case (opcode_d)
        OP_MOV_RB: begin
          desc_d.action = ACT_WRITE_REG;
          desc_d.register_index = modrm_d[5:3];
          desc_d.access_size = 3'd1;
        end
        OP_MOV_RV: begin
          desc_d.action = ACT_WRITE_REG;
          desc_d.register_index = modrm_d[5:3];
          desc_d.access_size = op4 ? 3'd4 : 3'd2;
        end
        OP_LD_RB: begin
          desc_d.action = ACT_READ_REG;
          desc_d.register_index = modrm_d[5:3];
          desc_d.access_size = 3'd1;
        end
        OP_LD_RV: begin
          desc_d.action = ACT_READ_REG;
          desc_d.register_index = modrm_d[5:3];
          desc_d.access_size = op4 ? 3'd4 : 3'd2;
        end
        OP_MOVZX_W: begin
          desc_d.action = ACT_READ_REG;
          desc_d.register_index = modrm_d[5:3];
          desc_d.access_size = 3'd2;
        end
        OP_LD_MOFS: begin
          desc_d.action = ACT_READ_REG;
          desc_d.access_size = op4 ? 3'd4 : 3'd2;
        end
        OP_ST_MOFS: begin
          desc_d.action = ACT_WRITE_REG;
          desc_d.access_size = op4 ? 3'd4 : 3'd2;
        end
        OP_MOVSB: begin
          desc_d.action = ACT_STRING;
          desc_d.access_size = 3'd1;
        end
        OP_MOVSV: begin
          desc_d.action = ACT_STRING;
          desc_d.access_size = op4 ? 3'd4 : 3'd2;
        end
        OP_MOV_IB: begin
          desc_d.action = ACT_WRITE_IMM;
          desc_d.access_size = 3'd1;
          desc_d.immediate_value = {24'd0, acc_d[31:24]};
        end
        OP_MOV_IV: begin
          desc_d.action = ACT_WRITE_IMM;
          desc_d.access_size = op4 ? 3'd4 : 3'd2;
          desc_d.immediate_value = op4 ? acc_d : {16'd0, acc_d[31:16]};
        end
        default: desc_d.action = ACT_ERROR;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      opsz_q    <= 1'b0;
      adsz_q    <= 1'b0;
      rep_q     <= 1'b0;
      seg_q     <= SEG_DS;
      opcode_q  <= 8'd0;
      modrm_q   <= 8'd0;
      skip_q    <= 3'd0;
      acc_q     <= 32'd0;
      imm_rem_q <= 3'd0;
      count_q   <= 4'd0;
    end else if (in_fire) begin
      if (emit) begin
        phase_q   <= PH_IDLE;
        opsz_q    <= 1'b0;
        adsz_q    <= 1'b0;
        rep_q     <= 1'b0;
        seg_q     <= SEG_DS;
        opcode_q  <= 8'd0;
        modrm_q   <= 8'd0;
        skip_q    <= 3'd0;
        acc_q     <= 32'd0;
        imm_rem_q <= 3'd0;
        count_q   <= 4'd0;
      end else begin
        phase_q   <= phase_d;
        opsz_q    <= opsz_d;
        adsz_q    <= adsz_d;
        rep_q     <= rep_d;
        seg_q     <= seg_d;
        opcode_q  <= opcode_d;
        modrm_q   <= modrm_d;
        skip_q    <= skip_d;
        acc_q     <= acc_d;
        imm_rem_q <= imm_rem_d;
        count_q   <= count_d;
      end
    end
  end

  // Output register; a transaction is loaded whenever a byte completes one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      desc_q <= desc_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign action_o             = desc_q.action;
  assign register_index_o     = desc_q.register_index;
  assign access_size_o        = desc_q.access_size;
  assign immediate_value_o    = desc_q.immediate_value;
  assign instruction_length_o = desc_q.instruction_length;
  assign segment_select_o     = desc_q.segment_select;
  assign repeat_flag_o        = desc_q.repeat_flag;
  assign address_size_o       = desc_q.addr_bytes;

  `MMD_ASSERT_IMPL(a_stall_blocks_input, out_valid_q && !out_ready_i, !in_ready_o,
    "byte taken while descriptor stalled")
  `MMD_ASSERT_IMPL(a_phase_onehot, 1'b1, $onehot(phase_q),
    "decode phase not one-hot")
  `MMD_ASSERT_IMPL(a_busy_has_bytes, phase_q != PH_IDLE, count_q != 4'd0,
    "open instruction with no bytes counted")
  `MMD_ASSERT_NEXT(a_emit_loads_output, in_fire && emit,
    out_valid_q && instruction_length_o != 4'd0,
    "completed instruction did not load a descriptor")

endmodule
